>>> hdl/pfr_pkg.sv
`default_nettype none

package pfr_pkg;

    // Widest values over the supported parameter range (FRAMES up to 64,
    // PAGE_BITS up to 32)
    localparam int PAGE_W_MAX   = 32;
    localparam int SLOT_W_MAX   = 6;
    localparam int CNT_W_MAX    = 7;
    localparam int STAMP_W      = 32;
    localparam int FC_W         = 5;
    localparam int IN_PAGE_W    = 16;
    localparam int OUT_PAGE_W   = 16;
    localparam int OUT_SLOT_W   = 4;
    localparam int CFG_IDX_W    = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'b1;

    // Replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    typedef logic [PAGE_W_MAX-1:0] page_t;
    typedef logic [SLOT_W_MAX-1:0] slot_t;
    typedef logic [STAMP_W-1:0]    stamp_t;
    typedef logic [CNT_W_MAX-1:0]  cnt_t;

    // Search record that walks down the row of frame cells
    typedef struct packed {
        logic   live;
        page_t  page;
        slot_t  rr_slot;
        logic   hit;
        slot_t  hit_slot;
        logic   empty;
        slot_t  empty_slot;
        stamp_t oldest;
        slot_t  oldest_slot;
        page_t  oldest_page;
        page_t  rr_page;
    } scan_t;

    // Broadcast update from the controller to every cell
    typedef struct packed {
        logic   clear;
        logic   write;
        logic   load_page;
        slot_t  slot;
        page_t  page;
        stamp_t stamp;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

>>> hdl/pfr_cell.sv
`default_nettype none

// One page frame: holds its page, valid bit and last-use stamp, and folds
// its contents into the search record that passes through it.
module pfr_cell
    import pfr_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int PAGE_BITS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire cnt_t      count,
    input  wire scan_t     scan_in,
    output scan_t          scan_out
);

    localparam slot_t MY_SLOT = slot_t'(IDX);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    stamp_t               stamp_reg;
    scan_t                scan_reg;
    scan_t                scan_next;
    page_t                page_ext;
    logic                 in_range;
    logic                 sel;

    assign page_ext = page_t'(page_reg);
    assign in_range = (cnt_t'(IDX) < count);
    assign sel      = ctl.write && (ctl.slot == MY_SLOT);

    // Fold this frame into the search record
    always_comb
    begin
        scan_next = scan_in;
        if (in_range)
        begin
            if (!scan_in.hit && valid_reg && (page_ext == scan_in.page))
            begin
                scan_next.hit      = 1'b1;
                scan_next.hit_slot = MY_SLOT;
            end
            if (!scan_in.empty && !valid_reg)
            begin
                scan_next.empty      = 1'b1;
                scan_next.empty_slot = MY_SLOT;
            end
            // oldest stamp, strict compare keeps ties on the lower slot
            if ((MY_SLOT == '0) || (stamp_reg < scan_in.oldest))
            begin
                scan_next.oldest      = stamp_reg;
                scan_next.oldest_slot = MY_SLOT;
                scan_next.oldest_page = page_ext;
            end
        end
        if (scan_in.rr_slot == MY_SLOT)
        begin
            scan_next.rr_page = page_ext;
        end
    end

    // Record hand-off to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

    // Valid bit and stamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            stamp_reg <= '0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
            stamp_reg <= '0;
        end
        else if (sel)
        begin
            stamp_reg <= ctl.stamp;
            if (ctl.load_page)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    // Resident page, meaningful only while valid
    always_ff @(posedge clk)
    begin
        if (sel && ctl.load_page)
        begin
            page_reg <= PAGE_BITS'(ctl.page);
        end
    end

endmodule

`default_nettype wire

>>> hdl/page_frame_replacement.sv
// Flow: an accepted request is registered as a search record, which steps
// through the register of each frame cell in turn and is then committed.
// A new request is not taken until the previous result has been loaded into
// the output register, so searches through the row of frame cells never overlap.
// Reset: rst_n is asynchronous, active low; it empties all frames, clears
// stamps and counters, and sets frame_count to 4 and the policy to FIFO.
`default_nettype none

module page_frame_replacement
    import pfr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [FC_W-1:0]       cfg_data,
    // page references
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] page_number
    input  wire logic [0:0]            s_tuser,   // [0] new_sequence
    // results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [55:0]                m_tdata,   // [3:0] frame_slot, [19:4] evicted_page,
                                                  // [51:20] fault_total, [55:52] zero
    output logic [2:0]                 m_tuser    // [0] page_hit, [1] evicted_valid,
                                                  // [2] stamp_overflow
);

    state_t                 state_reg, state_next;

    logic [FC_W-1:0]        fc_reg;
    logic                   pol_reg;
    cnt_t                   count;

    scan_t                  head_reg, head_next;
    scan_t                  chain [FRAMES+1];
    scan_t                  tail;
    cell_ctl_t              ctl;

    slot_t                  rr_reg, rr_next;
    stamp_t                 ref_reg, ref_next;
    stamp_t                 stamp_reg, stamp_next;
    stamp_t                 fault_reg, fault_next;

    logic                   res_hit_reg, res_hit_next;
    slot_t                  res_slot_reg, res_slot_next;
    logic                   res_ev_reg, res_ev_next;
    page_t                  res_evp_reg, res_evp_next;

    logic                   m_valid_reg;
    logic                   m_hit_reg, m_ev_reg, m_ovf_reg;
    logic [OUT_SLOT_W-1:0]  m_slot_reg;
    logic [OUT_PAGE_W-1:0]  m_evp_reg;
    stamp_t                 m_fault_reg;

    logic                   accept;
    logic                   commit;
    logic                   out_load;
    logic                   new_seq;
    logic [PAGE_BITS-1:0]   page_in;
    slot_t                  rr_base;
    stamp_t                 ref_base;
    cnt_t                   rr_inc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg  <= FC_W'(4);
            pol_reg <= POLICY_FIFO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_COUNT: fc_reg  <= cfg_data;
                CFG_POLICY:      pol_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Frames in use, clamped to 1..FRAMES
    always_comb
    begin
        if (fc_reg == '0)
        begin
            count = cnt_t'(1);
        end
        else if (32'(fc_reg) > 32'(FRAMES))
        begin
            count = cnt_t'(FRAMES);
        end
        else
        begin
            count = cnt_t'(fc_reg);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_SCAN;
            ST_SCAN: if (tail.live) state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready = 1'b0;
        commit   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SCAN: commit   = tail.live;
            ST_OUT:  out_load = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept  = s_tvalid && s_tready;
    assign new_seq = s_tuser[0];
    assign page_in = PAGE_BITS'(s_tdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Request intake, search launch and commit of the chosen frame
    always_comb
    begin
        head_next     = '0;
        ctl           = '0;
        rr_next       = rr_reg;
        ref_next      = ref_reg;
        stamp_next    = stamp_reg;
        fault_next    = fault_reg;
        res_hit_next  = res_hit_reg;
        res_slot_next = res_slot_reg;
        res_ev_next   = res_ev_reg;
        res_evp_next  = res_evp_reg;

        rr_base  = new_seq ? '0 : rr_reg;
        ref_base = new_seq ? '0 : ref_reg;
        rr_inc   = cnt_t'(tail.rr_slot) + cnt_t'(1);

        if (accept)
        begin
            head_next.live    = 1'b1;
            head_next.page    = page_t'(page_in);
            head_next.rr_slot = (cnt_t'(rr_base) >= count) ? '0 : rr_base;
            ctl.clear         = new_seq;
            stamp_next        = ref_base;
            ref_next          = (ref_base == STAMP_MAX) ? ref_base : ref_base + stamp_t'(1);
            if (new_seq)
            begin
                rr_next    = '0;
                fault_next = '0;
            end
        end

        if (commit)
        begin
            ctl.page      = tail.page;
            ctl.stamp     = stamp_reg;
            res_hit_next  = tail.hit;
            res_ev_next   = 1'b0;
            res_evp_next  = '0;
            if (tail.hit)
            begin
                ctl.write     = (pol_reg == POLICY_LRU);
                ctl.slot      = tail.hit_slot;
                res_slot_next = tail.hit_slot;
            end
            else
            begin
                ctl.write     = 1'b1;
                ctl.load_page = 1'b1;
                if (fault_reg != STAMP_MAX)
                begin
                    fault_next = fault_reg + stamp_t'(1);
                end
                if (tail.empty)
                begin
                    ctl.slot      = tail.empty_slot;
                    res_slot_next = tail.empty_slot;
                end
                else if (pol_reg == POLICY_LRU)
                begin
                    ctl.slot      = tail.oldest_slot;
                    res_slot_next = tail.oldest_slot;
                    res_ev_next   = 1'b1;
                    res_evp_next  = tail.oldest_page;
                end
                else
                begin
                    ctl.slot      = tail.rr_slot;
                    res_slot_next = tail.rr_slot;
                    res_ev_next   = 1'b1;
                    res_evp_next  = tail.rr_page;
                    rr_next       = (rr_inc >= count) ? '0 : slot_t'(rr_inc);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            rr_reg    <= '0;
            ref_reg   <= '0;
            fault_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            rr_reg    <= rr_next;
            ref_reg   <= ref_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg    <= stamp_next;
        res_hit_reg  <= res_hit_next;
        res_slot_reg <= res_slot_next;
        res_ev_reg   <= res_ev_next;
        res_evp_reg  <= res_evp_next;
    end

    // Row of frame cells
    assign chain[0] = head_reg;
    assign tail     = chain[FRAMES];

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        pfr_cell #(
            .IDX       (i),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .count    (count),
            .scan_in  (chain[i]),
            .scan_out (chain[i+1])
        );
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_hit_reg   <= res_hit_reg;
            m_slot_reg  <= OUT_SLOT_W'(res_slot_reg);
            m_ev_reg    <= res_ev_reg;
            m_evp_reg   <= OUT_PAGE_W'(res_evp_reg);
            m_fault_reg <= fault_reg;
            m_ovf_reg   <= (ref_reg == STAMP_MAX);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_fault_reg, m_evp_reg, m_slot_reg};
    assign m_tuser  = {m_ovf_reg, m_ev_reg, m_hit_reg};

endmodule

`default_nettype wire
